/* rtl/core/x86ea_pkg.sv */
// Shared types and constants for the ModRM/SIB effective address block.
// No dependencies; imported by every other file of the block except x86ea_ram.
package x86ea_pkg;

	localparam int unsigned REG_COUNT = 8;
	localparam int unsigned REG_W     = 32;
	localparam int unsigned RIDX_W    = $clog2(REG_COUNT);

	typedef logic [RIDX_W-1:0] ridx_t;
	typedef logic [2:0]        dlen_t;

	// register numbers
	localparam ridx_t REG_EBX = 3'd3;
	localparam ridx_t REG_ESP = 3'd4;
	localparam ridx_t REG_EBP = 3'd5;
	localparam ridx_t REG_ESI = 3'd6;
	localparam ridx_t REG_EDI = 3'd7;

	// ModRM fields
	localparam logic [1:0] MOD_NODISP = 2'd0;
	localparam logic [1:0] MOD_DISP8  = 2'd1;
	localparam logic [1:0] MOD_DISP32 = 2'd2;
	localparam logic [1:0] MOD_REG    = 2'd3;
	localparam logic [2:0] RM_SIB     = 3'd4;
	localparam logic [2:0] RM_DIRECT32 = 3'd5;
	localparam logic [2:0] RM_DIRECT16 = 3'd6;
	localparam ridx_t      SIB_NO_INDEX = 3'd4;
	localparam ridx_t      SIB_NO_BASE  = 3'd5;

	// displacement lengths in bytes
	localparam dlen_t DLEN_NONE = 3'd0;
	localparam dlen_t DLEN_8    = 3'd1;
	localparam dlen_t DLEN_16   = 3'd2;
	localparam dlen_t DLEN_32   = 3'd4;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_ADDR  = 1'b1;

	// decoded addressing form of one address transaction
	typedef struct packed {
		logic       use_base;
		ridx_t      base_idx;
		logic       use_index;
		ridx_t      index_idx;
		logic [1:0] scale;
		logic       wrap16;
		logic       seg_ss;
		dlen_t      dlen;
		logic       sib_used;
		logic       invalid;
	} ea_ctrl_t;

endpackage

/* rtl/core/x86ea_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on x86ea_pkg.
interface x86ea_req_if import x86ea_pkg::*; ();
	logic        valid;
	logic        ready;
	logic        func;
	logic [2:0]  reg_number;
	logic [31:0] reg_value;
	logic [7:0]  modrm_byte;
	logic [7:0]  sib_byte;
	logic [31:0] disp_bytes;
	logic        addr_size_32;

	modport source (output valid, func, reg_number, reg_value, modrm_byte, sib_byte,
		disp_bytes, addr_size_32, input ready);
	modport sink (input valid, func, reg_number, reg_value, modrm_byte, sib_byte,
		disp_bytes, addr_size_32, output ready);
endinterface

interface x86ea_rsp_if import x86ea_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [31:0] address;
	logic        segment_is_ss;
	dlen_t       disp_length;
	logic        sib_used;
	logic        invalid;

	modport source (output valid, address, segment_is_ss, disp_length, sib_used, invalid,
		input ready);
	modport sink (input valid, address, segment_is_ss, disp_length, sib_used, invalid,
		output ready);
endinterface

/* rtl/core/x86ea_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module x86ea_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end
endmodule

/* rtl/core/x86ea_decode.sv */
// Decodes ModRM, SIB and address size into the addressing form.
// Depends on x86ea_pkg.
module x86ea_decode import x86ea_pkg::*; (
	input  logic [7:0] modrm_byte,
	input  logic [7:0] sib_byte,
	input  logic       addr_size_32,
	output ea_ctrl_t   ctrl
);
	logic [1:0] md;
	logic [2:0] rm;
	ridx_t      sib_base;
	ridx_t      sib_index;
	logic       disp32_only;

	assign md        = modrm_byte[7:6];
	assign rm        = modrm_byte[2:0];
	assign sib_base  = sib_byte[2:0];
	assign sib_index = sib_byte[5:3];

	always_comb begin
		ctrl        = '0;
		disp32_only = 1'b0;
		if (md == MOD_REG) begin
			ctrl.invalid = 1'b1;
		end else if (addr_size_32) begin
			if (rm == RM_SIB) begin
				ctrl.sib_used  = 1'b1;
				ctrl.use_index = (sib_index != SIB_NO_INDEX);
				ctrl.index_idx = sib_index;
				ctrl.scale     = sib_byte[7:6];
				if (sib_base == SIB_NO_BASE && md == MOD_NODISP) begin
					disp32_only = 1'b1;
				end else begin
					ctrl.use_base = 1'b1;
					ctrl.base_idx = sib_base;
					ctrl.seg_ss   = (sib_base == REG_ESP) || (sib_base == REG_EBP);
				end
			end else if (rm == RM_DIRECT32 && md == MOD_NODISP) begin
				disp32_only = 1'b1;
			end else begin
				ctrl.use_base = 1'b1;
				ctrl.base_idx = rm;
				ctrl.seg_ss   = (rm == REG_EBP);
			end
			if (md == MOD_DISP8) begin
				ctrl.dlen = DLEN_8;
			end else if (md == MOD_DISP32 || disp32_only) begin
				ctrl.dlen = DLEN_32;
			end
		end else begin
			ctrl.wrap16 = 1'b1;
			case (rm)
				3'd0: begin
					ctrl.use_base  = 1'b1; ctrl.base_idx  = REG_EBX;
					ctrl.use_index = 1'b1; ctrl.index_idx = REG_ESI;
				end
				3'd1: begin
					ctrl.use_base  = 1'b1; ctrl.base_idx  = REG_EBX;
					ctrl.use_index = 1'b1; ctrl.index_idx = REG_EDI;
				end
				3'd2: begin
					ctrl.use_base  = 1'b1; ctrl.base_idx  = REG_EBP;
					ctrl.use_index = 1'b1; ctrl.index_idx = REG_ESI;
					ctrl.seg_ss    = 1'b1;
				end
				3'd3: begin
					ctrl.use_base  = 1'b1; ctrl.base_idx  = REG_EBP;
					ctrl.use_index = 1'b1; ctrl.index_idx = REG_EDI;
					ctrl.seg_ss    = 1'b1;
				end
				3'd4: begin
					ctrl.use_base = 1'b1; ctrl.base_idx = REG_ESI;
				end
				3'd5: begin
					ctrl.use_base = 1'b1; ctrl.base_idx = REG_EDI;
				end
				3'd6: begin
					// mod 0 here is a direct disp16
					if (md != MOD_NODISP) begin
						ctrl.use_base = 1'b1; ctrl.base_idx = REG_EBP;
						ctrl.seg_ss   = 1'b1;
					end
				end
				default: begin
					ctrl.use_base = 1'b1; ctrl.base_idx = REG_EBX;
				end
			endcase
			if (md == MOD_DISP8) begin
				ctrl.dlen = DLEN_8;
			end else if (md == MOD_DISP32 || (md == MOD_NODISP && rm == RM_DIRECT16)) begin
				ctrl.dlen = DLEN_16;
			end
		end
	end
endmodule

/* rtl/core/x86_modrm_effective_address.sv */
// Top level of the ModRM/SIB effective address generator.
// Depends on x86ea_pkg, x86ea_if, x86ea_ram and x86ea_decode.
//
// Takes one transaction per cycle on req. A register write (func 0) updates the
// general register file at the edge it is accepted and yields no result; the
// next accepted transaction already sees it. An address transaction is decoded
// and its two register reads (base, index) are issued to the 2-read RAM at
// acceptance into the input stage; the sum of base, scaled index and displacement
// is formed from the input stage and lands in the result register once that
// register is free, and the result is then offered on rsp. Sustained rate is
// one transaction per cycle while rsp takes each result; the sum is a single
// pass through one three-input 32-bit adder. A stalled result holds req.ready
// low only once the input stage is also full. Registers read as zero until first
// written (a valid bit per register).
module x86_modrm_effective_address import x86ea_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	x86ea_req_if.sink   req,
	x86ea_rsp_if.source rsp
);
	ea_ctrl_t ctrl;
	logic     req_acc;
	logic     wr_acc;
	logic     addr_acc;
	logic     out_free;

	logic [REG_COUNT-1:0] reg_valid_q;
	logic [REG_W-1:0]     base_rd;
	logic [REG_W-1:0]     index_rd;

	logic        valid_s1;
	ea_ctrl_t    ctrl_s1;
	logic        base_ok_s1;
	logic        index_ok_s1;
	logic [31:0] disp_s1;

	logic [31:0] base_v;
	logic [31:0] index_v;
	logic [31:0] index_sh;
	logic [31:0] disp_v;
	logic [31:0] sum;

	logic        rsp_valid_q;
	logic [31:0] address_q;
	logic        seg_ss_q;
	dlen_t       dlen_q;
	logic        sib_used_q;
	logic        invalid_q;

	x86ea_decode u_decode (
		.modrm_byte  (req.modrm_byte),
		.sib_byte    (req.sib_byte),
		.addr_size_32(req.addr_size_32),
		.ctrl        (ctrl)
	);

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || out_free;
	assign req_acc   = req.valid && req.ready;
	assign wr_acc    = req_acc && (req.func == FUNC_WRITE);
	assign addr_acc  = req_acc && (req.func == FUNC_ADDR);

	x86ea_ram #(
		.WIDTH(REG_W),
		.DEPTH(REG_COUNT)
	) u_gpr (
		.clk    (clk),
		.we     (wr_acc),
		.waddr  (req.reg_number),
		.wdata  (req.reg_value),
		.re     (addr_acc),
		.raddr_a(ctrl.base_idx),
		.raddr_b(ctrl.index_idx),
		.rdata_a(base_rd),
		.rdata_b(index_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_valid_q <= '0;
		end else if (wr_acc) begin
			reg_valid_q[req.reg_number] <= 1'b1;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (addr_acc) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (addr_acc) begin
			ctrl_s1     <= ctrl;
			base_ok_s1  <= reg_valid_q[ctrl.base_idx];
			index_ok_s1 <= reg_valid_q[ctrl.index_idx];
			disp_s1     <= req.disp_bytes;
		end
	end

	always_comb begin
		base_v  = (ctrl_s1.use_base && base_ok_s1) ? base_rd : 32'd0;
		index_v = (ctrl_s1.use_index && index_ok_s1) ? index_rd : 32'd0;
		if (ctrl_s1.wrap16) begin
			base_v  = {16'd0, base_v[15:0]};
			index_v = {16'd0, index_v[15:0]};
		end
		index_sh = index_v << ctrl_s1.scale;
		case (ctrl_s1.dlen)
			DLEN_8:  disp_v = {{24{disp_s1[7]}}, disp_s1[7:0]};
			DLEN_16: disp_v = {16'd0, disp_s1[15:0]};
			DLEN_32: disp_v = disp_s1;
			default: disp_v = 32'd0;
		endcase
		sum = base_v + index_sh + disp_v;
		if (ctrl_s1.wrap16) begin
			sum = {16'd0, sum[15:0]};
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			address_q  <= sum;
			seg_ss_q   <= ctrl_s1.seg_ss;
			dlen_q     <= ctrl_s1.dlen;
			sib_used_q <= ctrl_s1.sib_used;
			invalid_q  <= ctrl_s1.invalid;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.address       = address_q;
	assign rsp.segment_is_ss = seg_ss_q;
	assign rsp.disp_length   = dlen_q;
	assign rsp.sib_used      = sib_used_q;
	assign rsp.invalid       = invalid_q;
endmodule

/* rtl/core/x86ea_checker.sv */
// Port-level checks for the effective address block, bound to the top level.
// Depends on x86ea_pkg and x86_modrm_effective_address.
module x86ea_checker import x86ea_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_address,
	input logic        rsp_segment_is_ss,
	input dlen_t       rsp_disp_length,
	input logic        rsp_sib_used,
	input logic        rsp_invalid
);
	// a result waiting for the sink is held unchanged
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_address))
		else $error("result dropped or changed while stalled");

	// a new result follows an earlier accepted request transaction
	a_rsp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("result without a preceding request");

	// register operand: every address field is zero
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_invalid |-> rsp_address == 32'd0 && !rsp_segment_is_ss
			&& rsp_disp_length == DLEN_NONE && !rsp_sib_used)
		else $error("invalid result carries address fields");

	// 16-bit forms never take a SIB byte, and lengths are 0, 1, 2 or 4
	a_dlen_form: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_disp_length == DLEN_NONE || rsp_disp_length == DLEN_8
			|| rsp_disp_length == DLEN_32
			|| (rsp_disp_length == DLEN_16 && !rsp_sib_used)))
		else $error("bad displacement length");
endmodule

bind x86_modrm_effective_address x86ea_checker u_x86ea_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_address      (rsp.address),
	.rsp_segment_is_ss(rsp.segment_is_ss),
	.rsp_disp_length  (rsp.disp_length),
	.rsp_sib_used     (rsp.sib_used),
	.rsp_invalid      (rsp.invalid)
);
